@@ rtl/core/rvcd_pkg.sv @@
// Shared types and encodings for the compressed instruction decoder.
package rvcd_pkg;

    // Opcode quadrant, bits 1:0 of the word
    localparam logic [1:0] QUAD_0 = 2'b00;
    localparam logic [1:0] QUAD_1 = 2'b01;
    localparam logic [1:0] QUAD_2 = 2'b10;

    // funct3, bits 15:13
    localparam logic [2:0] F3_0 = 3'b000;
    localparam logic [2:0] F3_1 = 3'b001;
    localparam logic [2:0] F3_2 = 3'b010;
    localparam logic [2:0] F3_3 = 3'b011;
    localparam logic [2:0] F3_4 = 3'b100;
    localparam logic [2:0] F3_5 = 3'b101;
    localparam logic [2:0] F3_6 = 3'b110;
    localparam logic [2:0] F3_7 = 3'b111;

    // Quadrant 1 funct3 = 100 sub-group, bits 11:10
    localparam logic [1:0] ARITH_SRLI = 2'b00;
    localparam logic [1:0] ARITH_SRAI = 2'b01;
    localparam logic [1:0] ARITH_ANDI = 2'b10;
    localparam logic [1:0] ARITH_REG  = 2'b11;

    // Register-register group, bits 6:5
    localparam logic [1:0] RR_SUB = 2'b00;
    localparam logic [1:0] RR_XOR = 2'b01;
    localparam logic [1:0] RR_OR  = 2'b10;
    localparam logic [1:0] RR_AND = 2'b11;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    localparam int unsigned IMM_W = 18;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_XOR  = 4'd2,
        OP_OR   = 4'd3,
        OP_AND  = 4'd4,
        OP_SLL  = 4'd5,
        OP_SRL  = 4'd6,
        OP_SRA  = 4'd7,
        OP_JAL  = 4'd8,
        OP_JALR = 4'd9,
        OP_LW   = 4'd10,
        OP_SW   = 4'd11,
        OP_BEQ  = 4'd12,
        OP_BNE  = 4'd13
    } t_op;

    typedef enum logic [2:0] {
        UNIT_ALU    = 3'd0,
        UNIT_LOAD   = 3'd1,
        UNIT_STORE  = 3'd2,
        UNIT_BRANCH = 3'd3,
        UNIT_EBREAK = 3'd4
    } t_unit;

    typedef struct packed {
        logic [IMM_W-1:0] imm;
        t_op              op;
        t_unit            unit;
        logic [4:0]       rd;
        logic [4:0]       rs1;
        logic [4:0]       rs2;
        logic             uses_imm;
        logic             link_jump;
        logic             illegal;
    } t_uop;

endpackage

@@ rtl/core/rvc_compressed_decoder.sv @@
// RV32C compressed decoder. A 16-bit word is taken on any clock edge where
// start is high (busy is never raised, so one word per cycle is taken
// indefinitely). The decoded micro-op appears at the result register output,
// held for exactly one cycle and marked by o_valid; there is no back-pressure, so the
// receiver must capture it in that cycle or lose it. Latency is set by the
// input register and the result register around a single decode stage;
// throughput is one word per clock. Illegal words give o_illegal high with
// every other field zero.
module rvc_compressed_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_instr,
    output logic               o_valid,
    output logic signed [17:0] o_imm,
    output logic [3:0]         o_op_code,
    output logic [2:0]         o_unit,
    output logic [4:0]         o_dest_reg,
    output logic [4:0]         o_src1_reg,
    output logic [4:0]         o_src2_reg,
    output logic               o_uses_imm,
    output logic               o_is_link_jump,
    output logic               o_illegal
);

    // Input stage: word register plus its valid flag
    logic           r_in_vld;
    logic           n_in_vld;
    logic [15:0]    r_instr;

    // Result stage
    logic           r_out_vld;
    logic           n_out_vld;
    rvcd_pkg::t_uop r_uop;
    rvcd_pkg::t_uop n_uop;

    // Decoder never stalls; a fresh word may enter every cycle.
    assign busy      = 1'b0;
    assign n_in_vld  = start & ~busy;
    assign n_out_vld = r_in_vld;

    rvcd_decode u_decode (
        .i_instr (r_instr),
        .o_uop   (n_uop)
    );

    // Control flags: synchronous active-low reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload: captured only alongside a valid word, no reset needed
    always_ff @(posedge i_clk) begin
        if (n_in_vld) begin
            r_instr <= i_instr;
        end
        if (n_out_vld) begin
            r_uop <= n_uop;
        end
    end

    // Result ports straight from the result register
    assign o_valid        = r_out_vld;
    assign o_imm          = signed'(r_uop.imm);
    assign o_op_code      = r_uop.op;
    assign o_unit         = r_uop.unit;
    assign o_dest_reg     = r_uop.rd;
    assign o_src1_reg     = r_uop.rs1;
    assign o_src2_reg     = r_uop.rs2;
    assign o_uses_imm     = r_uop.uses_imm;
    assign o_is_link_jump = r_uop.link_jump;
    assign o_illegal      = r_uop.illegal;

endmodule

@@ rtl/core/rvcd_decode.sv @@
// Combinational decode of one 16-bit compressed word into a micro-op.
module rvcd_decode (
    input  logic [15:0]      i_instr,
    output rvcd_pkg::t_uop   o_uop
);

    logic [15:0] w;
    logic [2:0]  f3;
    logic [4:0]  rd_full;
    logic [4:0]  rs2_full;
    logic [4:0]  reg_a;
    logic [4:0]  reg_b;
    logic [17:0] imm6s;
    logic [17:0] jmp_ofs;
    rvcd_pkg::t_uop uop_zero;
    rvcd_pkg::t_uop uop_bad;

    assign w        = i_instr;
    assign f3       = w[15:13];
    assign rd_full  = w[11:7];
    assign rs2_full = w[6:2];
    // rd'/rs1'/rs2' map onto x8..x15
    assign reg_a    = {2'b01, w[9:7]};
    assign reg_b    = {2'b01, w[4:2]};

    assign imm6s   = {{12{w[12]}}, w[12], w[6:2]};
    assign jmp_ofs = {{6{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11],
                      w[5:3], 1'b0};

    always_comb begin
        uop_zero           = '0;
        uop_zero.op        = rvcd_pkg::OP_ADD;
        uop_zero.unit      = rvcd_pkg::UNIT_ALU;
        uop_bad            = uop_zero;
        uop_bad.illegal    = 1'b1;
    end

    always_comb begin
        o_uop = uop_zero;
        priority if (w == 16'h0000) begin
            o_uop = uop_bad;
        end else begin
            unique case (w[1:0])
                rvcd_pkg::QUAD_0: begin
                    unique case (f3)
                        rvcd_pkg::F3_0: begin  // addi4spn
                            o_uop.imm      = {8'b0, w[10:7], w[12:11], w[5], w[6], 2'b0};
                            o_uop.rd       = reg_b;
                            o_uop.rs1      = rvcd_pkg::REG_SP;
                            o_uop.uses_imm = 1'b1;
                        end
                        rvcd_pkg::F3_2: begin  // lw
                            o_uop.imm      = {11'b0, w[5], w[12:10], w[6], 2'b0};
                            o_uop.op       = rvcd_pkg::OP_LW;
                            o_uop.unit     = rvcd_pkg::UNIT_LOAD;
                            o_uop.rd       = reg_b;
                            o_uop.rs1      = reg_a;
                            o_uop.uses_imm = 1'b1;
                        end
                        rvcd_pkg::F3_6: begin  // sw
                            o_uop.imm      = {11'b0, w[5], w[12:10], w[6], 2'b0};
                            o_uop.op       = rvcd_pkg::OP_SW;
                            o_uop.unit     = rvcd_pkg::UNIT_STORE;
                            o_uop.rs1      = reg_a;
                            o_uop.rs2      = reg_b;
                            o_uop.uses_imm = 1'b1;
                        end
                        default: o_uop = uop_bad;
                    endcase
                end
                rvcd_pkg::QUAD_1: begin
                    o_uop.uses_imm = 1'b1;
                    unique case (f3)
                        rvcd_pkg::F3_0: begin  // addi
                            o_uop.imm = imm6s;
                            o_uop.rd  = rd_full;
                            o_uop.rs1 = rd_full;
                        end
                        rvcd_pkg::F3_1: begin  // jal, links to ra
                            o_uop.imm       = jmp_ofs;
                            o_uop.op        = rvcd_pkg::OP_JAL;
                            o_uop.rd        = rvcd_pkg::REG_RA;
                            o_uop.link_jump = 1'b1;
                        end
                        rvcd_pkg::F3_2: begin  // li
                            o_uop.imm = imm6s;
                            o_uop.rd  = rd_full;
                        end
                        rvcd_pkg::F3_3: begin
                            if (rd_full == rvcd_pkg::REG_SP) begin  // addi16sp
                                o_uop.imm = {{8{w[12]}}, w[12], w[4:3], w[5], w[2], w[6],
                                             4'b0};
                                o_uop.rd  = rvcd_pkg::REG_SP;
                                o_uop.rs1 = rvcd_pkg::REG_SP;
                                o_uop.rs2 = rvcd_pkg::REG_SP;
                            end else begin  // lui
                                o_uop.imm = {w[12], w[6:2], 12'b0};
                                o_uop.rd  = rd_full;
                            end
                        end
                        rvcd_pkg::F3_4: begin
                            o_uop.rd  = reg_a;
                            o_uop.rs1 = reg_a;
                            unique case (w[11:10])
                                rvcd_pkg::ARITH_SRLI: begin
                                    o_uop.imm = {12'b0, w[12], w[6:2]};
                                    o_uop.op  = rvcd_pkg::OP_SRL;
                                end
                                rvcd_pkg::ARITH_SRAI: begin
                                    o_uop.imm = {12'b0, w[12], w[6:2]};
                                    o_uop.op  = rvcd_pkg::OP_SRA;
                                end
                                rvcd_pkg::ARITH_ANDI: begin
                                    o_uop.imm = imm6s;
                                    o_uop.op  = rvcd_pkg::OP_AND;
                                end
                                rvcd_pkg::ARITH_REG: begin
                                    o_uop.rs2      = reg_b;
                                    o_uop.uses_imm = 1'b0;
                                    unique case (w[6:5])
                                        rvcd_pkg::RR_SUB: o_uop.op = rvcd_pkg::OP_SUB;
                                        rvcd_pkg::RR_XOR: o_uop.op = rvcd_pkg::OP_XOR;
                                        rvcd_pkg::RR_OR:  o_uop.op = rvcd_pkg::OP_OR;
                                        rvcd_pkg::RR_AND: o_uop.op = rvcd_pkg::OP_AND;
                                        default:          o_uop.op = rvcd_pkg::OP_SUB;
                                    endcase
                                end
                                default: o_uop = uop_bad;
                            endcase
                        end
                        rvcd_pkg::F3_5: begin  // j, as jal with x0
                            o_uop.imm       = jmp_ofs;
                            o_uop.op        = rvcd_pkg::OP_JAL;
                            o_uop.link_jump = 1'b1;
                        end
                        rvcd_pkg::F3_6, rvcd_pkg::F3_7: begin  // beqz / bnez
                            o_uop.imm  = {{9{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3],
                                          1'b0};
                            o_uop.op   = (f3 == rvcd_pkg::F3_6) ? rvcd_pkg::OP_BEQ
                                                                : rvcd_pkg::OP_BNE;
                            o_uop.unit = rvcd_pkg::UNIT_BRANCH;
                            o_uop.rs1  = reg_a;
                        end
                        default: o_uop = uop_bad;
                    endcase
                end
                rvcd_pkg::QUAD_2: begin
                    unique case (f3)
                        rvcd_pkg::F3_0: begin  // slli, rs2 mirrors rd
                            o_uop.imm      = {12'b0, w[12], w[6:2]};
                            o_uop.op       = rvcd_pkg::OP_SLL;
                            o_uop.rd       = rd_full;
                            o_uop.rs1      = rd_full;
                            o_uop.rs2      = rd_full;
                            o_uop.uses_imm = 1'b1;
                        end
                        rvcd_pkg::F3_2: begin  // lwsp
                            o_uop.imm      = {10'b0, w[3:2], w[12], w[6:4], 2'b0};
                            o_uop.op       = rvcd_pkg::OP_LW;
                            o_uop.unit     = rvcd_pkg::UNIT_LOAD;
                            o_uop.rd       = rd_full;
                            o_uop.rs1      = rvcd_pkg::REG_SP;
                            o_uop.uses_imm = 1'b1;
                        end
                        rvcd_pkg::F3_6: begin  // swsp
                            o_uop.imm      = {10'b0, w[8:7], w[12:9], 2'b0};
                            o_uop.op       = rvcd_pkg::OP_SW;
                            o_uop.unit     = rvcd_pkg::UNIT_STORE;
                            o_uop.rs1      = rvcd_pkg::REG_SP;
                            o_uop.rs2      = rs2_full;
                            o_uop.uses_imm = 1'b1;
                        end
                        rvcd_pkg::F3_4: begin
                            if (!w[12]) begin
                                priority if (rd_full == rvcd_pkg::REG_ZERO) begin
                                    o_uop = uop_bad;
                                end else if (rs2_full == rvcd_pkg::REG_ZERO) begin  // jr
                                    o_uop.op  = rvcd_pkg::OP_JALR;
                                    o_uop.rs1 = rd_full;
                                    o_uop.rs2 = rs2_full;
                                end else begin  // mv
                                    o_uop.rd  = rd_full;
                                    o_uop.rs2 = rs2_full;
                                end
                            end else begin
                                priority if (rs2_full == rvcd_pkg::REG_ZERO &&
                                             rd_full == rvcd_pkg::REG_ZERO) begin
                                    o_uop.unit = rvcd_pkg::UNIT_EBREAK;
                                end else if (rs2_full == rvcd_pkg::REG_ZERO) begin  // jalr
                                    o_uop.op  = rvcd_pkg::OP_JALR;
                                    o_uop.rd  = rvcd_pkg::REG_RA;
                                    o_uop.rs1 = rd_full;
                                    o_uop.rs2 = rs2_full;
                                end else if (rd_full != rvcd_pkg::REG_ZERO) begin  // add
                                    o_uop.rd  = rd_full;
                                    o_uop.rs1 = rd_full;
                                    o_uop.rs2 = rs2_full;
                                end else begin
                                    o_uop = uop_bad;
                                end
                            end
                        end
                        default: o_uop = uop_bad;
                    endcase
                end
                default: o_uop = uop_bad;  // quadrant 3 is not compressed
            endcase
        end
    end

endmodule

@@ dv/rvc_compressed_decoder_test.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the RV32C compressed decoder.
// Words are offered on start/busy and every decoded micro-op is checked field
// by field against a local decode of the same word. There is no back-pressure on
// the result side, so every o_valid cycle is taken as a delivered result.
module rvc_compressed_decoder_test;

    // Quadrant 3 is the uncompressed space; the package has no name for it
    localparam logic [1:0] QUAD_3 = 2'b11;

    // Cycles with neither a word taken nor a result seen before giving up.
    // The longest sender gap comes from pick_gap and the pipe is two deep.
    localparam int unsigned WATCHDOG_LIMIT = 400;
    // Settling time after the last result
    localparam int unsigned DRAIN_CYCLES = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        i_instr;
    logic               o_valid;
    logic signed [17:0] o_imm;
    logic [3:0]         o_op_code;
    logic [2:0]         o_unit;
    logic [4:0]         o_dest_reg;
    logic [4:0]         o_src1_reg;
    logic [4:0]         o_src2_reg;
    logic               o_uses_imm;
    logic               o_is_link_jump;
    logic               o_illegal;

    rvcd_pkg::t_uop expected_uops[$];
    int unsigned    error_count = 0;
    int unsigned    idle_cycles = 0;

    rvc_compressed_decoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_instr        (i_instr),
        .o_valid        (o_valid),
        .o_imm          (o_imm),
        .o_op_code      (o_op_code),
        .o_unit         (o_unit),
        .o_dest_reg     (o_dest_reg),
        .o_src1_reg     (o_src1_reg),
        .o_src2_reg     (o_src2_reg),
        .o_uses_imm     (o_uses_imm),
        .o_is_link_jump (o_is_link_jump),
        .o_illegal      (o_illegal)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decode prediction
    // ------------------------------------------------------------------

    function automatic rvcd_pkg::t_uop make_uop(input logic [17:0] imm,
                                                input rvcd_pkg::t_op op,
                                                input rvcd_pkg::t_unit unit,
                                                input logic [4:0] rd, input logic [4:0] rs1,
                                                input logic [4:0] rs2, input logic uses_imm,
                                                input logic link_jump);
        rvcd_pkg::t_uop u;
        u.imm       = imm;
        u.op        = op;
        u.unit      = unit;
        u.rd        = rd;
        u.rs1       = rs1;
        u.rs2       = rs2;
        u.uses_imm  = uses_imm;
        u.link_jump = link_jump;
        u.illegal   = 1'b0;
        return u;
    endfunction

    // Full decode of one compressed word. Anything not matched below stays
    // illegal with every other field zero.
    function automatic rvcd_pkg::t_uop decode_rvc(input logic [15:0] w);
        rvcd_pkg::t_uop u;
        rvcd_pkg::t_op  rr_op;
        logic [4:0]     rd_full;
        logic [4:0]     rs2_full;
        logic [4:0]     rd_c;
        logic [4:0]     rs2_c;
        logic [17:0]    imm6;
        logic [17:0]    jump_ofs;
        logic [17:0]    branch_ofs;
        logic [17:0]    word_ofs;
        logic [17:0]    shamt;

        rd_full  = w[11:7];
        rs2_full = w[6:2];
        // primed registers map onto x8..x15
        rd_c     = {2'b01, w[9:7]};
        rs2_c    = {2'b01, w[4:2]};

        imm6       = {{12{w[12]}}, w[12], w[6:2]};
        shamt      = {12'd0, w[12], w[6:2]};
        jump_ofs   = {{6{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
        branch_ofs = {{9{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
        // C.LW / C.SW offset, unsigned
        word_ofs   = {11'd0, w[5], w[12:10], w[6], 2'b00};

        rr_op = rvcd_pkg::OP_SUB;
        u = '0;
        u.illegal = 1'b1;

        if (w != 16'h0000) begin
            case (w[1:0])
                rvcd_pkg::QUAD_0: begin
                    case (w[15:13])
                        rvcd_pkg::F3_0:
                            u = make_uop({8'd0, w[10:7], w[12:11], w[5], w[6], 2'b00},
                                         rvcd_pkg::OP_ADD, rvcd_pkg::UNIT_ALU, rs2_c,
                                         rvcd_pkg::REG_SP, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                        rvcd_pkg::F3_2:
                            u = make_uop(word_ofs, rvcd_pkg::OP_LW, rvcd_pkg::UNIT_LOAD,
                                         rs2_c, rd_c, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                        rvcd_pkg::F3_6:
                            u = make_uop(word_ofs, rvcd_pkg::OP_SW, rvcd_pkg::UNIT_STORE,
                                         rvcd_pkg::REG_ZERO, rd_c, rs2_c, 1'b1, 1'b0);
                        default: ;
                    endcase
                end
                rvcd_pkg::QUAD_1: begin
                    case (w[15:13])
                        rvcd_pkg::F3_0:
                            u = make_uop(imm6, rvcd_pkg::OP_ADD, rvcd_pkg::UNIT_ALU, rd_full,
                                         rd_full, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                        rvcd_pkg::F3_1:
                            u = make_uop(jump_ofs, rvcd_pkg::OP_JAL, rvcd_pkg::UNIT_ALU,
                                         rvcd_pkg::REG_RA, rvcd_pkg::REG_ZERO,
                                         rvcd_pkg::REG_ZERO, 1'b1, 1'b1);
                        rvcd_pkg::F3_2:
                            u = make_uop(imm6, rvcd_pkg::OP_ADD, rvcd_pkg::UNIT_ALU, rd_full,
                                         rvcd_pkg::REG_ZERO, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                        rvcd_pkg::F3_3: begin
                            if (rd_full == rvcd_pkg::REG_SP) begin
                                // C.ADDI16SP: all three register fields are sp
                                u = make_uop({{8{w[12]}}, w[12], w[4:3], w[5], w[2], w[6],
                                              4'd0},
                                             rvcd_pkg::OP_ADD, rvcd_pkg::UNIT_ALU,
                                             rvcd_pkg::REG_SP, rvcd_pkg::REG_SP,
                                             rvcd_pkg::REG_SP, 1'b1, 1'b0);
                            end else begin
                                // C.LUI: upper immediate, rs1 is x0
                                u = make_uop({w[12], w[6:2], 12'd0}, rvcd_pkg::OP_ADD,
                                             rvcd_pkg::UNIT_ALU, rd_full, rvcd_pkg::REG_ZERO,
                                             rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                            end
                        end
                        rvcd_pkg::F3_4: begin
                            case (w[11:10])
                                rvcd_pkg::ARITH_SRLI:
                                    u = make_uop(shamt, rvcd_pkg::OP_SRL, rvcd_pkg::UNIT_ALU,
                                                 rd_c, rd_c, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                                rvcd_pkg::ARITH_SRAI:
                                    u = make_uop(shamt, rvcd_pkg::OP_SRA, rvcd_pkg::UNIT_ALU,
                                                 rd_c, rd_c, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                                rvcd_pkg::ARITH_ANDI:
                                    u = make_uop(imm6, rvcd_pkg::OP_AND, rvcd_pkg::UNIT_ALU,
                                                 rd_c, rd_c, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                                default: begin
                                    // register-register group, bit 12 not looked at
                                    case (w[6:5])
                                        rvcd_pkg::RR_SUB: rr_op = rvcd_pkg::OP_SUB;
                                        rvcd_pkg::RR_XOR: rr_op = rvcd_pkg::OP_XOR;
                                        rvcd_pkg::RR_OR:  rr_op = rvcd_pkg::OP_OR;
                                        default:          rr_op = rvcd_pkg::OP_AND;
                                    endcase
                                    u = make_uop(18'd0, rr_op, rvcd_pkg::UNIT_ALU, rd_c, rd_c,
                                                 rs2_c, 1'b0, 1'b0);
                                end
                            endcase
                        end
                        // C.J comes out as a jal with rd x0
                        rvcd_pkg::F3_5:
                            u = make_uop(jump_ofs, rvcd_pkg::OP_JAL, rvcd_pkg::UNIT_ALU,
                                         rvcd_pkg::REG_ZERO, rvcd_pkg::REG_ZERO,
                                         rvcd_pkg::REG_ZERO, 1'b1, 1'b1);
                        rvcd_pkg::F3_6:
                            u = make_uop(branch_ofs, rvcd_pkg::OP_BEQ, rvcd_pkg::UNIT_BRANCH,
                                         rvcd_pkg::REG_ZERO, rd_c, rvcd_pkg::REG_ZERO,
                                         1'b1, 1'b0);
                        default:
                            u = make_uop(branch_ofs, rvcd_pkg::OP_BNE, rvcd_pkg::UNIT_BRANCH,
                                         rvcd_pkg::REG_ZERO, rd_c, rvcd_pkg::REG_ZERO,
                                         1'b1, 1'b0);
                    endcase
                end
                rvcd_pkg::QUAD_2: begin
                    case (w[15:13])
                        // C.SLLI keeps rs2 equal to rd
                        rvcd_pkg::F3_0:
                            u = make_uop(shamt, rvcd_pkg::OP_SLL, rvcd_pkg::UNIT_ALU, rd_full,
                                         rd_full, rd_full, 1'b1, 1'b0);
                        rvcd_pkg::F3_2:
                            u = make_uop({10'd0, w[3:2], w[12], w[6:4], 2'b00},
                                         rvcd_pkg::OP_LW, rvcd_pkg::UNIT_LOAD, rd_full,
                                         rvcd_pkg::REG_SP, rvcd_pkg::REG_ZERO, 1'b1, 1'b0);
                        rvcd_pkg::F3_6:
                            u = make_uop({10'd0, w[8:7], w[12:9], 2'b00}, rvcd_pkg::OP_SW,
                                         rvcd_pkg::UNIT_STORE, rvcd_pkg::REG_ZERO,
                                         rvcd_pkg::REG_SP, rs2_full, 1'b1, 1'b0);
                        rvcd_pkg::F3_4: begin
                            if (!w[12]) begin
                                // C.JR / C.MV; rd field of zero is illegal
                                if (rd_full != rvcd_pkg::REG_ZERO) begin
                                    if (rs2_full == rvcd_pkg::REG_ZERO)
                                        u = make_uop(18'd0, rvcd_pkg::OP_JALR,
                                                     rvcd_pkg::UNIT_ALU, rvcd_pkg::REG_ZERO,
                                                     rd_full, rs2_full, 1'b0, 1'b0);
                                    else
                                        u = make_uop(18'd0, rvcd_pkg::OP_ADD,
                                                     rvcd_pkg::UNIT_ALU, rd_full,
                                                     rvcd_pkg::REG_ZERO, rs2_full,
                                                     1'b0, 1'b0);
                                end
                            end else begin
                                // C.EBREAK / C.JALR / C.ADD
                                if (rs2_full == rvcd_pkg::REG_ZERO &&
                                    rd_full == rvcd_pkg::REG_ZERO)
                                    u = make_uop(18'd0, rvcd_pkg::OP_ADD,
                                                 rvcd_pkg::UNIT_EBREAK, rvcd_pkg::REG_ZERO,
                                                 rvcd_pkg::REG_ZERO, rvcd_pkg::REG_ZERO,
                                                 1'b0, 1'b0);
                                else if (rs2_full == rvcd_pkg::REG_ZERO)
                                    u = make_uop(18'd0, rvcd_pkg::OP_JALR, rvcd_pkg::UNIT_ALU,
                                                 rvcd_pkg::REG_RA, rd_full, rs2_full,
                                                 1'b0, 1'b0);
                                else if (rd_full != rvcd_pkg::REG_ZERO)
                                    u = make_uop(18'd0, rvcd_pkg::OP_ADD, rvcd_pkg::UNIT_ALU,
                                                 rd_full, rd_full, rs2_full, 1'b0, 1'b0);
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        return u;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [17:0] exp_val,
                                 input logic [17:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // Push on acceptance and pop on o_valid in one block, so a word that is
    // taken and a result that arrives in the same cycle never race.
    always @(posedge i_clk) begin
        rvcd_pkg::t_uop exp_uop;
        if (i_rst_n) begin
            if (start && !busy)
                expected_uops.push_back(decode_rvc(i_instr));
            if (o_valid) begin
                if (expected_uops.size() == 0) begin
                    $display("%0t: result with nothing expected, actual imm 0x%0h op %0d",
                             $time, o_imm, o_op_code);
                    error_count++;
                end else begin
                    exp_uop = expected_uops.pop_front();
                    compare_field("imm",          exp_uop.imm,            o_imm);
                    compare_field("op_code",      18'(exp_uop.op),        18'(o_op_code));
                    compare_field("unit",         18'(exp_uop.unit),      18'(o_unit));
                    compare_field("dest_reg",     18'(exp_uop.rd),        18'(o_dest_reg));
                    compare_field("src1_reg",     18'(exp_uop.rs1),       18'(o_src1_reg));
                    compare_field("src2_reg",     18'(exp_uop.rs2),       18'(o_src2_reg));
                    compare_field("uses_imm",     18'(exp_uop.uses_imm),  18'(o_uses_imm));
                    compare_field("is_link_jump", 18'(exp_uop.link_jump),
                                  18'(o_is_link_jump));
                    compare_field("illegal",      18'(exp_uop.illegal),   18'(o_illegal));
                end
            end
        end
    end

    // Watchdog: any cycle that moves a word either way resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $time, expected_uops.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short pauses, the odd long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one word, wait until it is taken, then idle for the given gap with
    // junk on the instruction bus
    task automatic drive_word(input logic [15:0] w, input int unsigned gap);
        @(negedge i_clk);
        start   <= 1'b1;
        i_instr <= w;
        do @(posedge i_clk); while (busy);
        repeat (gap) begin
            @(negedge i_clk);
            start   <= 1'b0;
            i_instr <= 16'($urandom);
        end
    endtask

    task automatic drive_list(input logic [15:0] words[]);
        foreach (words[k])
            drive_word(words[k], pick_gap());
    endtask

    // Zero word, quadrant 3, FP loads/stores, reserved code, bad C.JR/C.MV/C.ADD
    task automatic test_illegal_words();
        drive_list('{16'h0000, 16'hFFFF, 16'h2000, 16'h8000, 16'h8002, 16'h9006,
                     16'hE002});
    endtask

    // Quadrant 0 with every immediate bit set
    task automatic test_quadrant0();
        drive_list('{16'h1FFC, 16'h5FFC, 16'hDFFC});
    endtask

    // addi, jal, addi16sp, lui, srli with shamt bit 5, srai, andi, the four
    // register ops (or with bit 12 set), j, beqz with every offset bit set, bnez of zero
    task automatic test_quadrant1();
        drive_list('{16'h1FFD, 16'h3FFD, 16'h717D, 16'h7FFD, 16'h93FD, 16'h847D,
                     16'h9BFD, 16'h8C89, 16'h8C3D, 16'h9C41, 16'h8FFD, 16'hBFFD,
                     16'hDFFD, 16'hE001});
    endtask

    // slli, lwsp, swsp, jr, mv, ebreak, jalr, add
    task automatic test_quadrant2();
        drive_list('{16'h1FFE, 16'h5FFE, 16'hDFFE, 16'h8082, 16'h8FFE, 16'h9002,
                     16'h9F82, 16'h9F86});
    endtask

    // Random words biased onto the three compressed quadrants, with register
    // fields pulled to x0 or sp often enough to hit the register-dependent forms.
    // Every 100 words starts with a run of 20 back-to-back.
    task automatic test_random_words(input int unsigned count);
        logic [15:0] w;
        int unsigned sel;
        for (int unsigned n = 0; n < count; n++) begin
            w   = 16'($urandom);
            sel = $urandom_range(0, 9);
            case (sel)
                0:       w[1:0] = QUAD_3;
                1, 2, 3: w[1:0] = rvcd_pkg::QUAD_0;
                4, 5, 6: w[1:0] = rvcd_pkg::QUAD_1;
                default: w[1:0] = rvcd_pkg::QUAD_2;
            endcase
            // raw noise now and then, quadrant 3 included
            if ($urandom_range(0, 15) == 0)
                w = 16'($urandom);
            if ($urandom_range(0, 5) == 0)
                w[6:2] = rvcd_pkg::REG_ZERO;
            if ($urandom_range(0, 5) == 0)
                w[11:7] = rvcd_pkg::REG_ZERO;
            else if ($urandom_range(0, 7) == 0)
                w[11:7] = rvcd_pkg::REG_SP;
            if ($urandom_range(0, 199) == 0)
                w = 16'h0000;
            drive_word(w, (n % 100 < 20) ? 0 : pick_gap());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_instr = 16'h0000;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_illegal_words();
        test_quadrant0();
        test_quadrant1();
        test_quadrant2();
        test_random_words(1300);

        @(negedge i_clk);
        start <= 1'b0;

        // drain; the watchdog covers a result that never comes
        while (expected_uops.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (expected_uops.size() != 0) begin
            $display("%0t: %0d decoded words never arrived", $time, expected_uops.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rvcd_pkg.sv
rtl/core/rvcd_decode.sv
rtl/core/rvc_compressed_decoder.sv
dv/rvc_compressed_decoder_test.sv
